// File: hdl/step_rate_history_window_average_macros.svh
// Assertion macros shared by the checker of the step-rate history block.
`ifndef STEP_RATE_HISTORY_WINDOW_AVERAGE_MACROS_SVH
`define STEP_RATE_HISTORY_WINDOW_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRHWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRHWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/srhwa_pkg.sv
// Package with sizes, codes and shared types of the step-rate history block.
`default_nettype none
package srhwa_pkg;

  // Table depth and derived widths.
  localparam int unsigned HistDepth = 1024;
  localparam int unsigned AddrW     = $clog2(HistDepth);
  localparam int unsigned CntW      = $clog2(HistDepth + 1);

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  // Result status codes.
  localparam logic StatusDone = 1'b0;
  localparam logic StatusFull = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  // Request to the divider.
  typedef struct packed {
    logic               start;
    logic signed [63:0] area;
    logic        [31:0] len;
  } div_req_t;

  // Answer from the divider.
  typedef struct packed {
    logic               done;
    logic signed [31:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: hdl/srhwa_if.sv
// Channel interfaces for input items and result items.
`default_nettype none
interface srhwa_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic        [31:0] time_a;
  logic        [31:0] time_b;
  logic signed [31:0] rate_value;

  modport source (output valid, kind, time_a, time_b, rate_value, input ready);
  modport sink   (input valid, kind, time_a, time_b, rate_value, output ready);
endinterface

interface srhwa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] average;
  logic               status;

  modport source (output valid, average, status, input ready);
  modport sink   (input valid, average, status, output ready);
endinterface
`default_nettype wire

// File: hdl/srhwa_hist.sv
// History table memory: change times and rates, one write and one registered read port.
`default_nettype none
module srhwa_hist (
  input  wire logic                      clk_i,
  input  wire logic                      wr_en_i,
  input  wire logic [srhwa_pkg::AddrW-1:0] wr_addr_i,
  input  wire logic [31:0]               wr_time_i,
  input  wire logic signed [31:0]        wr_rate_i,
  input  wire logic [srhwa_pkg::AddrW-1:0] rd_addr_i,
  output logic [31:0]                    rd_time_o,
  output logic signed [31:0]             rd_rate_o
);
  import srhwa_pkg::*;

  logic        [31:0] time_mem [HistDepth];
  logic signed [31:0] rate_mem [HistDepth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_mem[wr_addr_i] <= wr_time_i;
      rate_mem[wr_addr_i] <= wr_rate_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_time_o <= time_mem[rd_addr_i];
    rd_rate_o <= rate_mem[rd_addr_i];
  end

endmodule
`default_nettype wire

// File: hdl/srhwa_div.sv
// Restoring divider: signed 64-bit area by unsigned 32-bit length, one bit per cycle.
`default_nettype none
module srhwa_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire srhwa_pkg::div_req_t req_i,
  output srhwa_pkg::div_rsp_t      rsp_o
);
  import srhwa_pkg::*;

  localparam int unsigned Steps = 64;
  localparam int unsigned StepW = $clog2(Steps);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [31:0]      rem_q, rem_d;
  logic [63:0]      quo_q, quo_d;
  logic [31:0]      len_q, len_d;
  logic             neg_q, neg_d;
  logic [32:0]      rem_sh;
  logic [32:0]      rem_sub;
  logic             sat;

  // One shift-and-subtract step per cycle.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    len_d   = len_q;
    neg_d   = neg_q;
    rem_sh  = {rem_q, quo_q[63]};
    rem_sub = rem_sh - {1'b0, len_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      len_d  = req_i.len;
      neg_d  = req_i.area[63];
      quo_d  = req_i.area[63] ? 64'(-req_i.area) : 64'(req_i.area);
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, len_q}) begin
        rem_d = rem_sub[31:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    len_q <= len_d;
    neg_q <= neg_d;
  end

  // Sign and saturation of the quotient.
  assign sat = |quo_q[63:31];
  always_comb begin
    rsp_o.done = done_q;
    if (neg_q) begin
      rsp_o.quotient = sat ? 32'sh8000_0000 : $signed(-quo_q[31:0]);
    end else begin
      rsp_o.quotient = sat ? 32'sh7fff_ffff : $signed(quo_q[31:0]);
    end
  end

endmodule
`default_nettype wire

// File: hdl/step_rate_history_window_average.sv
// Record, clear and unused items: result in the cycle after acceptance, next item after handoff.
// Query: one table entry per cycle through the table read port and the shared multiplier,
// up to the first entry later than the window end or the end of the table (at most 1024
// entries); the area is then divided by the window length in the divider, which is skipped
// when no entry is in force or the window is not positive. One item at a time; reset clears
// the entry count and control, table contents stay undefined.
`default_nettype none
module step_rate_history_window_average (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  srhwa_in_if.sink    in_i,
  srhwa_out_if.source out_o
);
  import srhwa_pkg::*;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    issue_q, issue_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_first_q, rd_first_d;
  logic               have_q, have_d;
  logic               past_q, past_d;
  logic               prod_vld_q, prod_vld_d;
  logic [31:0]        start_q, start_d;
  logic [31:0]        end_q, end_d;
  logic [31:0]        s_q, s_d;
  logic [31:0]        prev_time_q, prev_time_d;
  logic signed [31:0] prev_rate_q, prev_rate_d;
  logic [63:0]        prod_q, prod_d;
  logic [63:0]        area_q, area_d;
  logic signed [31:0] avg_q, avg_d;
  logic               status_q, status_d;

  logic               wr_en;
  logic               issue;
  logic [31:0]        rd_time;
  logic signed [31:0] rd_rate;
  logic               in_run;
  logic               past_new;
  logic [31:0]        lo_time;
  logic [31:0]        mul_hi;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // Table storage.
  srhwa_hist u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_time_i (in_i.time_a),
    .wr_rate_i (in_i.rate_value),
    .rd_addr_i (issue_q[AddrW-1:0]),
    .rd_time_o (rd_time),
    .rd_rate_o (rd_rate)
  );

  // Iterative divider for the final average.
  srhwa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Shared multiplier: interval length times rate.
  assign lo_time = past_q ? prev_time_q : s_q;
  assign mul_a   = $signed({1'b0, mul_hi}) - $signed({1'b0, lo_time});
  assign mul_b   = prev_rate_q;
  assign mul_p   = mul_a * mul_b;

  // Scan decode of the entry returned by the table.
  assign in_run   = rd_vld_q && (rd_time <= end_q);
  assign past_new = past_q || (rd_time > s_q);

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_first_d  = 1'b0;
    have_d      = have_q;
    past_d      = past_q;
    prod_vld_d  = 1'b0;
    start_d     = start_q;
    end_d       = end_q;
    s_d         = s_q;
    prev_time_d = prev_time_q;
    prev_rate_d = prev_rate_q;
    prod_d      = prod_q;
    area_d      = prod_vld_q ? (area_q + prod_q) : area_q;
    avg_d       = avg_q;
    status_d    = status_q;
    wr_en       = 1'b0;
    issue       = 1'b0;
    mul_hi      = end_q;
    div_req     = '{start: 1'b0, area: $signed(area_q), len: end_q - start_q};
    in_i.ready  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          avg_d    = '0;
          status_d = StatusDone;
          state_d  = ST_OUT;
          case (kind_e'(in_i.kind))
            KIND_RECORD: begin
              if (count_q < CntW'(HistDepth)) begin
                wr_en   = 1'b1;
                count_d = count_q + CntW'(1);
              end else begin
                status_d = StatusFull;
              end
            end
            KIND_QUERY: begin
              start_d = in_i.time_a;
              end_d   = in_i.time_b;
              issue_d = '0;
              have_d  = 1'b0;
              past_d  = 1'b0;
              area_d  = '0;
              state_d = ST_SCAN;
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Consume the entry read last cycle.
        if (in_run) begin
          prev_time_d = rd_time;
          prev_rate_d = rd_rate;
          if (rd_first_q) begin
            have_d = 1'b1;
            s_d    = (start_q < rd_time) ? rd_time : start_q;
          end else begin
            past_d = past_new;
            if (past_new) begin
              mul_hi     = rd_time;
              prod_d     = mul_p[63:0];
              prod_vld_d = 1'b1;
            end
          end
        end
        // Stop at the first later entry or at the end of the table.
        if ((rd_vld_q && !in_run) || (!rd_vld_q && (issue_q == count_q))) begin
          state_d = ST_FINAL;
        end else if (issue_q < count_q) begin
          issue      = 1'b1;
          issue_d    = issue_q + CntW'(1);
          rd_vld_d   = 1'b1;
          rd_first_d = (issue_q == '0);
        end
      end

      ST_FINAL: begin
        if (!have_q) begin
          avg_d   = '0;
          state_d = ST_OUT;
        end else if (end_q <= start_q) begin
          avg_d   = prev_rate_q;
          state_d = ST_OUT;
        end else begin
          mul_hi     = end_q;
          prod_d     = mul_p[63:0];
          prod_vld_d = 1'b1;
          state_d    = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_d = ST_DIV_START;
      end

      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          avg_d   = div_rsp.quotient;
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      issue_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      have_q     <= 1'b0;
      past_q     <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      issue_q    <= issue_d;
      rd_vld_q   <= rd_vld_d && issue;
      rd_first_q <= rd_first_d;
      have_q     <= have_d;
      past_q     <= past_d;
      prod_vld_q <= prod_vld_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    end_q       <= end_d;
    s_q         <= s_d;
    prev_time_q <= prev_time_d;
    prev_rate_q <= prev_rate_d;
    prod_q      <= prod_d;
    area_q      <= area_d;
    avg_q       <= avg_d;
    status_q    <= status_d;
  end

  // Result channel.
  assign out_o.valid   = (state_q == ST_OUT);
  assign out_o.average = avg_q;
  assign out_o.status  = status_q;

endmodule
`default_nettype wire

// File: hdl/srhwa_checker.sv
// Port-level checker for the step-rate history block and its bind.
`default_nettype none
`include "step_rate_history_window_average_macros.svh"
module srhwa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] average_i,
  input wire logic        status_i
);
  import srhwa_pkg::*;

  // A stalled result keeps its payload.
  `SRHWA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(average_i) && $stable(status_i), "stalled result changed")

  // Only one item is in the block at a time.
  `SRHWA_ASSERT_IMP(a_one_item, clk_i, rst_ni, out_valid_i, !in_ready_i, "input ready while a result waits")

  // An accepted transaction closes the input right after it is taken.
  `SRHWA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input ready right after a transaction")

  // A dropped record carries a zero average.
  `SRHWA_ASSERT_IMP(a_full_zero, clk_i, rst_ni, out_valid_i && (status_i == StatusFull), average_i == 32'd0, "full status with nonzero average")

endmodule

bind step_rate_history_window_average srhwa_checker u_srhwa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .average_i   (out_o.average),
  .status_i    (out_o.status)
);
`default_nettype wire

// File: sim/step_rate_history_window_average_tb.sv
// Self-checking testbench for the step-rate history block with window averages.
`default_nettype none
module step_rate_history_window_average_tb;
  import srhwa_pkg::*;

  // Clock and reset.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  srhwa_in_if  in_ch ();
  srhwa_out_if out_ch ();

  step_rate_history_window_average i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // One expected result.
  typedef struct packed {
    logic signed [31:0] average;
    logic               status;
  } answer_t;

  // Predicted table contents.
  logic [31:0] hist_time [HistDepth];
  logic [31:0] hist_rate [HistDepth];
  int unsigned hist_count;

  answer_t     answer_q[$];
  int unsigned error_count;
  longint      cycle_count;
  bit          idle_enable;
  int unsigned hold_cycles;

  // Leading entries whose time is at or below t.
  function automatic int unsigned count_at_or_below(logic [31:0] t);
    int unsigned i;
    i = 0;
    while (i < hist_count && hist_time[i] <= t) i++;
    return i;
  endfunction

  // Time-weighted average of the step function over [ws, we].
  function automatic logic [31:0] predict_average(logic [31:0] ws, logic [31:0] we);
    int unsigned n_end, idx, end_idx;
    logic [31:0] cur, s;
    logic [63:0] area, mag, quo;
    if (hist_count == 0) return 32'd0;
    n_end = count_at_or_below(we);
    if (we <= ws) return (n_end != 0) ? hist_rate[n_end-1] : 32'd0;
    if (n_end == 0) return 32'd0;
    end_idx = n_end - 1;
    s = (ws < hist_time[0]) ? hist_time[0] : ws;
    idx = count_at_or_below(s);
    idx = (idx != 0) ? idx - 1 : 0;
    cur = (hist_time[idx] > s) ? hist_time[idx] : s;
    area = 64'd0;
    while (idx < end_idx) begin
      area += ({32'd0, hist_time[idx+1]} - {32'd0, cur}) *
              {{32{hist_rate[idx][31]}}, hist_rate[idx]};
      idx++;
      cur = hist_time[idx];
    end
    area += ({32'd0, we} - {32'd0, cur}) * {{32{hist_rate[end_idx][31]}}, hist_rate[end_idx]};
    mag = area[63] ? -area : area;
    quo = mag / {32'd0, we - ws};
    if (area[63]) return (quo >= 64'h8000_0000) ? 32'h8000_0000 : -quo[31:0];
    return (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
  endfunction

  // Updates the predicted table and queues the expected result.
  task automatic predict_item(logic [1:0] kind, logic [31:0] ta, logic [31:0] tb,
                              logic [31:0] rv);
    answer_t a;
    a.average = '0;
    a.status  = StatusDone;
    case (kind)
      KIND_RECORD: begin
        if (hist_count < HistDepth) begin
          hist_time[hist_count] = ta;
          hist_rate[hist_count] = rv;
          hist_count++;
        end else begin
          a.status = StatusFull;
        end
      end
      KIND_QUERY: a.average = predict_average(ta, tb);
      KIND_CLEAR: hist_count = 0;
      default: ;
    endcase
    answer_q = {answer_q, a};
  endtask

  task automatic report_mismatch(string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Sends one transaction, with an optional random gap first. Valid stays high after
  // acceptance so that a following transaction can go out back to back.
  task automatic send_item(logic [1:0] kind, logic [31:0] ta, logic [31:0] tb,
                           logic [31:0] rv);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.time_a     <= ta;
    in_ch.time_b     <= tb;
    in_ch.rate_value <= rv;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_item(kind, ta, tb, rv);
  endtask

  // Releases the input and waits until every expected result has come.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of every field and the named special cases.
  task automatic test_directed();
    send_item(KIND_QUERY, 32'd0, 32'd100, 32'd0);           // empty table
    send_item(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_RECORD, 32'd100, 32'hFFFF_FFFF, 32'h0001_0000);
    send_item(KIND_RECORD, 32'd200, 32'd0, 32'h8000_0000);
    send_item(KIND_RECORD, 32'd300, 32'd0, 32'h7FFF_FFFF);
    send_item(KIND_QUERY, 32'd0, 32'd50, 32'd0);            // before first entry
    send_item(KIND_QUERY, 32'd0, 32'd150, 32'd0);           // straddles first entry
    send_item(KIND_QUERY, 32'd150, 32'd250, 32'd0);
    send_item(KIND_QUERY, 32'd250, 32'd250, 32'd0);         // zero window
    send_item(KIND_QUERY, 32'd400, 32'd10, 32'd0);          // negative window
    send_item(KIND_QUERY, 32'd300, 32'd301, 32'd0);         // most positive
    send_item(KIND_QUERY, 32'd200, 32'd201, 32'd0);         // most negative
    send_item(KIND_QUERY, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_item(KIND_RECORD, 32'd50, 32'd0, 32'hFFFF_0000);   // out of order
    send_item(KIND_QUERY, 32'd0, 32'd1000, 32'd0);
    send_item(KIND_QUERY, 32'd60, 32'd250, 32'd0);
    send_item(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_item(KIND_QUERY, 32'd0, 32'd10, 32'd0);
    wait_drained();
  endtask

  // Fills the table and records beyond its end.
  task automatic test_full_table();
    logic [31:0] t;
    t = 32'd0;
    repeat (HistDepth + 3) begin
      t += $urandom_range(1, 5000);
      send_item(KIND_RECORD, t, $urandom, $urandom);
    end
    send_item(KIND_QUERY, 32'd0, t + 32'd10, 32'd0);
    send_item(KIND_QUERY, t / 2, t / 2 + 32'd77777, 32'd0);
    send_item(KIND_CLEAR, 32'd0, 32'd0, 32'd0);
    wait_drained();
  endtask

  // Random mix: mostly short ordered histories with queries, some noise.
  task automatic test_random(int unsigned n_items);
    logic [31:0] t;
    int unsigned k;
    t = $urandom_range(0, 1000);
    for (int unsigned i = 0; i < n_items; i++) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        t += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000);
        send_item(KIND_RECORD, t, $urandom, ($urandom_range(0, 3) == 0) ? $urandom
                  : $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      end else if (k < 85) begin
        logic [31:0] ws;
        ws = ($urandom_range(0, 4) == 0) ? $urandom : t - $urandom_range(0, 20000);
        send_item(KIND_QUERY, ws, ($urandom_range(0, 5) == 0) ? $urandom
                  : ws + $urandom_range(0, 30000), $urandom);
      end else if (k < 90) begin
        send_item(KIND_CLEAR, $urandom, $urandom, $urandom);
        t = $urandom_range(0, 1000);
      end else if (k < 93) begin
        send_item(KIND_UNUSED, $urandom, $urandom, $urandom);
      end else begin
        send_item(KIND_RECORD, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Long receiver stall while the sender keeps offering items.
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int unsigned i = 0; i < 8; i++)
      send_item(KIND_RECORD, 32'd1000 * i, 32'd0, $urandom);
    send_item(KIND_QUERY, 32'd0, 32'd9000, 32'd0);
    wait_drained();
  endtask

  // Receiver: random stalls and the long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Checks each result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (answer_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        answer_t a;
        a = answer_q.pop_front();
        if (out_ch.average !== a.average)
          report_mismatch($sformatf("average %h, expected %h", out_ch.average, a.average));
        if (out_ch.status !== a.status)
          report_mismatch($sformatf("status %b, expected %b", out_ch.status, a.status));
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd10_000_000) begin
      $display("** step_rate_history_window_average: FAILED **");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.time_a = '0;
    in_ch.time_b = '0;
    in_ch.rate_value = '0;
    hist_count = 0;
    error_count = 0;
    cycle_count = 0;
    hold_cycles = 0;
    idle_enable = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(300);
    test_full_table();
    idle_enable = 1'b0;
    test_random(150);
    wait_drained();
    repeat (1200) @(posedge clk_i);
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("** step_rate_history_window_average: PASSED **");
    end else begin
      $display("** step_rate_history_window_average: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
